### design/mrt_pkg.sv
// Shared types and constants for the 4x4 matrix row transform.
`timescale 1ns / 1ps

package mrt_pkg;

  localparam int N_COLS       = 4;
  localparam int N_ROWS       = 4;
  localparam int ROW_W        = 2;
  localparam int DATA_W       = 32;
  localparam int PROD_W       = 2 * DATA_W;
  localparam int PAIR_W       = PROD_W + 1;
  localparam int SUM_W        = PROD_W + 2;
  localparam int FRAC_BITS_DEF = 16;

  // operation codes of a request
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MUL  = 1'b1;

  typedef logic signed [DATA_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef elem_t elem_row_t [N_COLS];
  typedef prod_t prod_row_t [N_COLS];

  // control that travels beside the product data
  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] row;
  } tag_t;

endpackage

### design/mrt_lane.sv
// One lane: holds one row of the right matrix and multiplies it by one left element.
`timescale 1ns / 1ps

module mrt_lane (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  mrt_pkg::elem_row_t wr_data,
  input  logic              mul_en,
  input  mrt_pkg::elem_t    a,
  output mrt_pkg::prod_row_t prod
);
  import mrt_pkg::*;

  elem_t m [N_COLS];

  // stored matrix row, zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < N_COLS; j++) m[j] <= '0;
    end else if (wr_en) begin
      for (int j = 0; j < N_COLS; j++) m[j] <= wr_data[j];
    end
  end

  // four registered 32x32 signed products
  always_ff @(posedge clk) begin
    if (mul_en) begin
      for (int j = 0; j < N_COLS; j++) prod[j] <= a * m[j];
    end
  end

endmodule

### design/mrt_merge.sv
// Merge stage: sums lane products per column, shifts, saturates, holds the result.
`timescale 1ns / 1ps

module mrt_merge #(
  parameter int FRAC_BITS = mrt_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mrt_pkg::tag_t              tag,
  input  mrt_pkg::prod_row_t         prod [mrt_pkg::N_ROWS],
  output logic                       ready,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic [mrt_pkg::ROW_W-1:0]  result_row,
  output mrt_pkg::elem_row_t         result
);
  import mrt_pkg::*;

  localparam sum_t SAT_MAX = {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam sum_t SAT_MIN = {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  logic             v2;
  logic [ROW_W-1:0] r2;
  pair_t            lo2 [N_COLS];
  pair_t            hi2 [N_COLS];
  logic             ready3;
  sum_t             sum3 [N_COLS];
  sum_t             shf3 [N_COLS];

  assign ready3 = !rsp_valid || !rsp_stall;
  assign ready  = !v2 || ready3;

  // stage 2: pairwise sums of lane products
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready) begin
      v2 <= tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && tag.valid) begin
      r2 <= tag.row;
      for (int j = 0; j < N_COLS; j++) begin
        lo2[j] <= PAIR_W'(prod[0][j]) + PAIR_W'(prod[1][j]);
        hi2[j] <= PAIR_W'(prod[2][j]) + PAIR_W'(prod[3][j]);
      end
    end
  end

  // final add, arithmetic shift, saturation
  always_comb begin
    for (int j = 0; j < N_COLS; j++) begin
      sum3[j] = SUM_W'(lo2[j]) + SUM_W'(hi2[j]);
      shf3[j] = sum3[j] >>> FRAC_BITS;
    end
  end

  // stage 3: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ready3) begin
      rsp_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && v2) begin
      result_row <= r2;
      for (int j = 0; j < N_COLS; j++) begin
        if (shf3[j] > SAT_MAX)      result[j] <= {1'b0, {(DATA_W-1){1'b1}}};
        else if (shf3[j] < SAT_MIN) result[j] <= {1'b1, {(DATA_W-1){1'b0}}};
        else                        result[j] <= shf3[j][DATA_W-1:0];
      end
    end
  end

endmodule

### design/matrix_row_transform_4x4.sv
// Top level of the 4x4 matrix row transform in signed fixed point.
`timescale 1ns / 1ps

// Usage:
// The request channel (req_valid / req_stall) carries operation, row_index
// and elem0..elem3. A load request (operation 0) writes that row of the
// stored right matrix at the accepting edge and yields no response. A
// multiply request (operation 1) yields one response on rsp_valid /
// rsp_stall: result_row and out0..out3, the left row times the stored
// matrix, shifted right by FRAC_BITS and saturated to 32 bits.
// Four lanes, one per matrix row, each hold their row and form four 32x32
// products; a merge stage adds the lanes per column.
// Pipeline: the product registers load at the accepting edge, then the
// pairwise sum registers, then the output register that raises rsp_valid.
// Throughput: one request per cycle without stalls (per-stage handshake).
// A load that follows a multiply does not affect it; the multiply reads the
// matrix at its accepting edge.
// Reset clears the stored matrix to zero and empties the pipeline.
// When the receiver stalls, the output holds; earlier stages keep filling
// until full, then req_stall rises.
module matrix_row_transform_4x4 #(
  parameter int FRAC_BITS = mrt_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic                       operation,
  input  logic [mrt_pkg::ROW_W-1:0]  row_index,
  input  mrt_pkg::elem_t             elem0,
  input  mrt_pkg::elem_t             elem1,
  input  mrt_pkg::elem_t             elem2,
  input  mrt_pkg::elem_t             elem3,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic [mrt_pkg::ROW_W-1:0]  result_row,
  output mrt_pkg::elem_t             out0,
  output mrt_pkg::elem_t             out1,
  output mrt_pkg::elem_t             out2,
  output mrt_pkg::elem_t             out3
);
  import mrt_pkg::*;

  elem_row_t        row_in;
  elem_row_t        result;
  prod_row_t        prod [N_ROWS];
  logic             accept;
  logic             do_mul;
  logic             ready1;
  logic             merge_ready;
  logic             v1;
  logic [ROW_W-1:0] r1;
  tag_t             tag1;

  assign row_in[0] = elem0;
  assign row_in[1] = elem1;
  assign row_in[2] = elem2;
  assign row_in[3] = elem3;

  // stage 1 handshake
  assign ready1    = !v1 || merge_ready;
  assign req_stall = !ready1;
  assign accept    = req_valid && ready1;
  assign do_mul    = accept && (operation == OP_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= do_mul;
    end
  end

  always_ff @(posedge clk) begin
    if (do_mul) r1 <= row_index;
  end

  assign tag1.valid = v1;
  assign tag1.row   = r1;

  // one lane per right-matrix row
  for (genvar k = 0; k < N_ROWS; k++) begin : g_lane
    mrt_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .wr_en   (accept && (operation == OP_LOAD) && (row_index == ROW_W'(k))),
      .wr_data (row_in),
      .mul_en  (do_mul),
      .a       (row_in[k]),
      .prod    (prod[k])
    );
  end

  mrt_merge #(
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .tag        (tag1),
    .prod       (prod),
    .ready      (merge_ready),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .result_row (result_row),
    .result     (result)
  );

  assign out0 = result[0];
  assign out1 = result[1];
  assign out2 = result[2];
  assign out3 = result[3];

endmodule
